// ----- hw/rtl/u8d_pkg.sv -----
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, codes and the transition table of the utf-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned DFA_W   = 4;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned NUM_DFA = 9;
    localparam int unsigned NUM_CLS = 12;

    localparam logic [DFA_W-1:0] DFA_ACCEPT = 4'd0;
    localparam logic [DFA_W-1:0] DFA_REJECT = 4'd1;
    localparam logic [DFA_W-1:0] DFA_LAST   = 4'd8;

    localparam logic [CP_W-1:0] BMP_MAX = 21'h00FFFF;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CORRUPT  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [DFA_W-1:0] dfa_state;
        logic [CP_W-1:0]  partial_code;
        logic             discarding;
    } t_dec_state;

    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code_point;
        t_status          status;
        logic             string_done;
    } t_step_res;

    localparam logic [DFA_W-1:0] STEP_TABLE [NUM_DFA][NUM_CLS] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
        logic [CLASS_W-1:0] cls;
        if (b < 8'h80) begin
            cls = 4'd0;
        end else if (b < 8'h90) begin
            cls = 4'd1;
        end else if (b < 8'hA0) begin
            cls = 4'd9;
        end else if (b < 8'hC0) begin
            cls = 4'd7;
        end else if (b < 8'hC2) begin
            cls = 4'd8;
        end else if (b < 8'hE0) begin
            cls = 4'd2;
        end else if (b == 8'hE0) begin
            cls = 4'd10;
        end else if (b == 8'hED) begin
            cls = 4'd4;
        end else if (b < 8'hF0) begin
            cls = 4'd3;
        end else if (b == 8'hF0) begin
            cls = 4'd11;
        end else if (b < 8'hF4) begin
            cls = 4'd6;
        end else if (b == 8'hF4) begin
            cls = 4'd5;
        end else begin
            cls = 4'd8;
        end
        return cls;
    endfunction

endpackage

// ----- hw/rtl/u8d_if.sv -----
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channels of the utf-8 decoder: byte items in, code point items out.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        string_done;

    modport source (output valid, output code_point, output status, output string_done,
                    input ready);
    modport sink   (input valid, input code_point, input status, input string_done,
                    output ready);
endinterface

// ----- hw/rtl/u8d_step.sv -----
// ----------------------------------------------------------------------------
// u8d_step
// One decoder step: byte class, table transition, code point assembly, errors.
// ----------------------------------------------------------------------------
module u8d_step (
    input  u8d_pkg::t_dec_state i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_eot,
    input  logic                i_limit,
    output u8d_pkg::t_dec_state o_state,
    output u8d_pkg::t_step_res  o_res
);
    import u8d_pkg::*;

    logic [CLASS_W-1:0] cls;
    logic [DFA_W-1:0]   cur;
    logic [DFA_W-1:0]   nxt;
    logic [CP_W-1:0]    pc;
    logic [7:0]         lead_mask;

    always_comb begin
        cls       = byte_class(i_byte);
        cur       = (i_state.dfa_state > DFA_LAST) ? DFA_REJECT : i_state.dfa_state;
        lead_mask = 8'hFF >> cls;
        if (cur != DFA_ACCEPT) begin
            pc = {i_state.partial_code[CP_W-7:0], i_byte[5:0]};
        end else begin
            pc = {{(CP_W-8){1'b0}}, lead_mask & i_byte};
        end
        nxt = STEP_TABLE[cur][cls];

        o_state          = i_state;
        o_res.valid       = 1'b0;
        o_res.code_point  = '0;
        o_res.status      = STATUS_OK;
        o_res.string_done = 1'b1;

        if (i_state.discarding) begin
            if (i_eot) begin
                o_state = '{dfa_state: DFA_ACCEPT, partial_code: '0, discarding: 1'b0};
            end
        end else if (nxt == DFA_REJECT || (nxt != DFA_ACCEPT && i_eot)) begin
            o_state      = '{dfa_state: DFA_ACCEPT, partial_code: '0, discarding: !i_eot};
            o_res.valid  = 1'b1;
            o_res.status = STATUS_CORRUPT;
        end else if (nxt != DFA_ACCEPT) begin
            o_state = '{dfa_state: nxt, partial_code: pc, discarding: 1'b0};
        end else if (i_limit && pc > BMP_MAX) begin
            o_state      = '{dfa_state: DFA_ACCEPT, partial_code: '0, discarding: !i_eot};
            o_res.valid  = 1'b1;
            o_res.status = STATUS_TOO_LONG;
        end else begin
            o_state           = '{dfa_state: DFA_ACCEPT, partial_code: '0, discarding: 1'b0};
            o_res.valid       = 1'b1;
            o_res.code_point  = pc;
            o_res.string_done = i_eot;
        end
    end

endmodule

// ----- hw/rtl/utf8_to_codepoint_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Streaming utf-8 decoder: bytes in, unicode code points or error codes out.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one byte per item plus end_of_text on the last byte of a
//   string. o_out carries code_point, status (ok, corrupt, too long) and
//   string_done. Both channels are valid/ready.
//   i_cfg_we/i_cfg_wdata write limit_to_bmp; write it only while idle.
//   An accepted byte sits in the input register and is decoded into the
//   result register once that register is free or its result is taken.
//   Throughput: one byte per cycle unless the receiver stalls; the decoder
//   state loop is a single table lookup and shift between the input and
//   result registers.
//   Bytes that only open or continue a sequence, and bytes dropped after an
//   error until end_of_text, give no result.
//   Reset clears both valid flags, the decoder state and limit_to_bmp.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more byte, then i_in.ready drops until the result drains.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    u8d_byte_if.sink     i_in,
    u8d_cp_if.source     o_out
);
    import u8d_pkg::*;

    logic             r_limit;
    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_eot;
    t_dec_state       r_state;
    t_dec_state       n_state;
    t_step_res        n_res;
    logic             r_out_valid;
    logic [CP_W-1:0]  r_code_point;
    t_status          r_status;
    logic             r_string_done;
    logic             out_free;
    logic             advance;

    u8d_step u_step (
        .i_state (r_state),
        .i_byte  (r_byte),
        .i_eot   (r_eot),
        .i_limit (r_limit),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 1'b0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.in_byte;
            r_eot  <= i_in.end_of_text;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{dfa_state: DFA_ACCEPT, partial_code: '0, discarding: 1'b0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res.valid) begin
            r_code_point  <= n_res.code_point;
            r_status      <= n_res.status;
            r_string_done <= n_res.string_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.code_point  = r_code_point;
    assign o_out.status      = r_status;
    assign o_out.string_done = r_string_done;

    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != STATUS_OK |-> r_code_point == '0)
        else $error("error item with nonzero code point");

    a_err_ends_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != STATUS_OK |-> r_string_done)
        else $error("error item without string_done");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.dfa_state != DFA_REJECT && r_state.dfa_state <= DFA_LAST)
        else $error("decoder state out of range");

    a_discard_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.discarding |-> r_state.dfa_state == DFA_ACCEPT
                               && r_state.partial_code == '0)
        else $error("discarding with open sequence");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_code_point)
                                        && $stable(r_status) && $stable(r_string_done))
        else $error("result changed while stalled");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the utf-8 to code point decoder. Byte items are
// queued as directed strings and then as random strings, mostly well-formed
// utf-8 with random code points and some corrupted, truncated or pure noise.
// An in-bench decoder works out each expected code point or error. A monitor
// compares every accepted result against it, under random sender gaps,
// receiver stalls and both settings of the bmp limit.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    typedef enum logic [3:0] {
        SQ_IDLE     = 4'd0,
        SQ_BAD      = 4'd1,
        SQ_NEED1    = 4'd2,
        SQ_NEED2    = 4'd3,
        SQ_AFTER_E0 = 4'd4,
        SQ_AFTER_ED = 4'd5,
        SQ_AFTER_F0 = 4'd6,
        SQ_AFTER_F1 = 4'd7,
        SQ_AFTER_F4 = 4'd8
    } t_seq_state;

    localparam logic [3:0] KIND_ASCII = 4'd0;
    localparam logic [3:0] KIND_C80   = 4'd1;
    localparam logic [3:0] KIND_LEAD2 = 4'd2;
    localparam logic [3:0] KIND_LEAD3 = 4'd3;
    localparam logic [3:0] KIND_ED    = 4'd4;
    localparam logic [3:0] KIND_F4    = 4'd5;
    localparam logic [3:0] KIND_F1    = 4'd6;
    localparam logic [3:0] KIND_CA0   = 4'd7;
    localparam logic [3:0] KIND_BAD   = 4'd8;
    localparam logic [3:0] KIND_C90   = 4'd9;
    localparam logic [3:0] KIND_E0    = 4'd10;
    localparam logic [3:0] KIND_F0    = 4'd11;

    localparam int PHASE_BYTES = 450;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        t_status         status;
        logic            string_done;
    } t_cp_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    u8d_byte_if byte_ch();
    u8d_cp_if   cp_ch();

    utf8_to_codepoint_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (byte_ch),
        .o_out       (cp_ch)
    );

    always #5ns i_clk = ~i_clk;

    // decoder state mirrored in the bench
    t_seq_state      seq_state = SQ_IDLE;
    logic [CP_W-1:0] cp_accum  = '0;
    logic            dropping  = 1'b0;
    logic            bmp_only  = 1'b0;

    t_byte_item byte_backlog[$];
    t_cp_result cp_expected[$];
    logic [7:0] text_bytes[$];

    int bytes_queued = 0;
    int bytes_sent   = 0;
    int fail_count   = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    logic steady     = 1'b0;
    logic [9:0] stall_clk = '0;

    function automatic logic [3:0] byte_kind(input logic [7:0] b);
        logic [3:0] k;
        if (b < 8'h80)       k = KIND_ASCII;
        else if (b < 8'h90)  k = KIND_C80;
        else if (b < 8'hA0)  k = KIND_C90;
        else if (b < 8'hC0)  k = KIND_CA0;
        else if (b < 8'hC2)  k = KIND_BAD;
        else if (b < 8'hE0)  k = KIND_LEAD2;
        else if (b == 8'hE0) k = KIND_E0;
        else if (b == 8'hED) k = KIND_ED;
        else if (b < 8'hF0)  k = KIND_LEAD3;
        else if (b == 8'hF0) k = KIND_F0;
        else if (b < 8'hF4)  k = KIND_F1;
        else if (b == 8'hF4) k = KIND_F4;
        else                 k = KIND_BAD;
        return k;
    endfunction

    function automatic t_seq_state step_seq(input t_seq_state s, input logic [3:0] k);
        logic any_cont;
        t_seq_state n;
        any_cont = (k == KIND_C80) || (k == KIND_C90) || (k == KIND_CA0);
        n = SQ_BAD;
        case (s)
            SQ_IDLE: begin
                case (k)
                    KIND_ASCII: n = SQ_IDLE;
                    KIND_LEAD2: n = SQ_NEED1;
                    KIND_LEAD3: n = SQ_NEED2;
                    KIND_E0:    n = SQ_AFTER_E0;
                    KIND_ED:    n = SQ_AFTER_ED;
                    KIND_F0:    n = SQ_AFTER_F0;
                    KIND_F1:    n = SQ_AFTER_F1;
                    KIND_F4:    n = SQ_AFTER_F4;
                    default:    n = SQ_BAD;
                endcase
            end
            SQ_NEED1:    if (any_cont) n = SQ_IDLE;
            SQ_NEED2:    if (any_cont) n = SQ_NEED1;
            SQ_AFTER_E0: if (k == KIND_CA0) n = SQ_NEED1;
            SQ_AFTER_ED: if (k == KIND_C80 || k == KIND_C90) n = SQ_NEED1;
            SQ_AFTER_F0: if (k == KIND_C90 || k == KIND_CA0) n = SQ_NEED2;
            SQ_AFTER_F1: if (any_cont) n = SQ_NEED2;
            SQ_AFTER_F4: if (k == KIND_C80) n = SQ_NEED2;
            default:     n = SQ_BAD;
        endcase
        return n;
    endfunction

    // returns 1 when the byte produces a result item
    function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                         output t_cp_result res);
        logic [3:0] k;
        t_seq_state n;
        res = '{code_point: '0, status: STATUS_OK, string_done: 1'b1};
        if (dropping) begin
            if (last) begin
                dropping  = 1'b0;
                seq_state = SQ_IDLE;
                cp_accum  = '0;
            end
            return 1'b0;
        end
        k = byte_kind(b);
        if (seq_state != SQ_IDLE) cp_accum = {cp_accum[CP_W-7:0], b[5:0]};
        else                      cp_accum = {13'd0, (8'hFF >> k) & b};
        n = step_seq(seq_state, k);
        seq_state = n;
        if (n == SQ_BAD || (n != SQ_IDLE && last) ||
            (n == SQ_IDLE && bmp_only && cp_accum > 21'h00FFFF)) begin
            res.status = (n == SQ_IDLE) ? STATUS_TOO_LONG : STATUS_CORRUPT;
            seq_state  = SQ_IDLE;
            cp_accum   = '0;
            dropping   = !last;
            return 1'b1;
        end
        if (n != SQ_IDLE) return 1'b0;
        res.code_point  = cp_accum;
        res.string_done = last;
        cp_accum        = '0;
        return 1'b1;
    endfunction

    // sender: bursts of items separated by random gaps
    always @(posedge i_clk) begin : drive_bytes
        t_byte_item item;
        t_cp_result res;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                if (decode_byte(byte_ch.in_byte, byte_ch.end_of_text, res))
                    cp_expected.push_back(res);
                bytes_sent++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (gap_left != 0 || byte_backlog.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    byte_ch.valid <= 1'b0;
                end else begin
                    item = byte_backlog.pop_front();
                    byte_ch.valid       <= 1'b1;
                    byte_ch.in_byte     <= item.data;
                    byte_ch.end_of_text <= item.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = (steady || $urandom_range(0, 2) == 0) ? 0
                                                                        : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern, cycling through four modes
    always @(posedge i_clk) begin
        stall_clk <= stall_clk + 1'b1;
        case (stall_clk[9:8])
            2'd0:    cp_ch.ready <= 1'b1;
            2'd1:    cp_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    cp_ch.ready <= (stall_clk[3:0] < 4'd5);
            default: cp_ch.ready <= stall_clk[0];
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_cp_result want;
        if (i_rst_n && cp_ch.valid && cp_ch.ready) begin
            if (cp_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: cp=%h status=%0d done=%b",
                             cp_ch.code_point, cp_ch.status, cp_ch.string_done);
            end else begin
                want = cp_expected.pop_front();
                if (cp_ch.code_point !== want.code_point || cp_ch.status !== want.status ||
                    cp_ch.string_done !== want.string_done) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp cp=%h st=%0d done=%b, got cp=%h st=%0d done=%b",
                                 want.code_point, want.status, want.string_done,
                                 cp_ch.code_point, cp_ch.status, cp_ch.string_done);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        byte_backlog.push_back('{data: b, last: last});
        bytes_queued++;
    endtask

    task automatic append_utf8(input int unsigned cp);
        if (cp < 'h80) begin
            text_bytes.push_back(cp[7:0]);
        end else if (cp < 'h800) begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 'h10000) begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic add_random_string();
        int n;
        int style;
        int pick;
        int idx;
        n     = $urandom_range(1, 8);
        style = $urandom_range(0, 9);
        text_bytes.delete();
        if (style == 0) begin
            // noise, with end marks anywhere
            repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            repeat (n) begin
                pick = $urandom_range(0, 12);
                if (pick < 3)       append_utf8($urandom_range(0, 'h7F));
                else if (pick < 6)  append_utf8($urandom_range('h80, 'h7FF));
                else if (pick < 9)  append_utf8($urandom_range('h800, 'hFFFF));
                else if (pick < 12) append_utf8($urandom_range('h10000, 'h10FFFF));
                else                append_utf8($urandom_range('h110000, 'h1FFFFF));
            end
            idx = $urandom_range(0, text_bytes.size() - 1);
            case (style)
                1: text_bytes[idx] = 8'($urandom_range(0, 255));
                2: begin
                    if (text_bytes.size() > 1) void'(text_bytes.pop_back());
                    else text_bytes[0] = 8'hE1;
                end
                3: text_bytes.insert(idx, 8'h80 | 8'($urandom_range(0, 63)));
                default: ;
            endcase
            foreach (text_bytes[i]) push_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    task automatic add_random_phase();
        int start;
        start = bytes_queued;
        while (bytes_queued - start < PHASE_BYTES) add_random_string();
    endtask

    // no config write while a byte may still be in the pipeline
    task automatic wait_idle();
        do @(posedge i_clk);
        while (bytes_sent != bytes_queued || cp_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        bmp_only     = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.in_byte     = '0;
        byte_ch.end_of_text = 1'b0;
        cp_ch.ready         = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        push_byte(8'hC2, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hED, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hF4, 1'b0);
        push_byte(8'h8F, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        // rejected byte, then the rest of the string is dropped
        push_byte(8'hFF, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b1);
        // string ends inside a sequence
        push_byte(8'hE0, 1'b0);
        push_byte(8'hA0, 1'b1);
        // rejected byte that also ends the string
        push_byte(8'h80, 1'b1);
        add_random_phase();

        write_limit(1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h41, 1'b1);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        add_random_phase();

        write_limit(1'b0);
        steady = 1'b1;
        add_random_phase();

        write_limit(1'b1);
        steady = 1'b0;
        add_random_phase();

        wait_idle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
